@@ hw/rtl/line_frequency_meter_unit_defines.svh @@
// line_frequency_meter_unit_defines.svh
// assertion macros used by the checker file of the line frequency meter
// no dependencies
`ifndef LINE_FREQUENCY_METER_UNIT_DEFINES_SVH
`define LINE_FREQUENCY_METER_UNIT_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define LFM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define LFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lfm_pkg.sv @@
// lfm_pkg.sv
// widths, constants and shared types of the line frequency meter
// no dependencies
`default_nettype none

package lfm_pkg;

    localparam int PERIOD_W = 16;
    localparam int FREQ_W   = 10;
    localparam int SIXTH_W  = 12;
    localparam int Q6_W     = 14;
    localparam int RUN_W    = 8;
    localparam int STEP_W   = 4;

    localparam logic [PERIOD_W-1:0] GOOD_LO = 16'd16000;
    localparam logic [PERIOD_W-1:0] GOOD_HI = 16'd22000;
    localparam logic [PERIOD_W-1:0] FREQ_HI = 16'd25000;

    localparam logic [Q6_W-1:0]    SIXTH_LO   = 14'd2700;
    localparam logic [Q6_W-1:0]    SIXTH_HI   = 14'd3400;
    localparam logic [SIXTH_W-1:0] SIXTH_50HZ = 12'd3333;
    localparam logic [SIXTH_W-1:0] SIXTH_60HZ = 12'd2777;

    localparam logic [FREQ_W-1:0] FREQ_MIN = 10'd400;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 10'd625;

    localparam logic [RUN_W-1:0] RUN_MAX   = 8'd255;
    localparam logic [RUN_W-1:0] RUN_LIMIT = 8'd3;

    // 10000000 split as (9765 << 10) + 640; quotient fits in 10 bits
    localparam logic [PERIOD_W-1:0] DIV_PRE   = 16'd9765;
    localparam logic [FREQ_W-1:0]   DIV_LOW   = 10'd640;
    localparam logic [STEP_W-1:0]   DIV_STEPS = 4'd10;
    localparam logic [STEP_W-1:0]   LAST_STEP = 4'd15;

    localparam logic CFG_AUTO = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    typedef struct packed {
        logic              done;
        logic [FREQ_W-1:0] freq_q;
        logic [Q6_W-1:0]   sixth;
    } t_div_sts;

endpackage

`default_nettype wire

@@ hw/rtl/line_frequency_meter_unit.sv @@
// Line frequency meter. Each transfer on the input channel is one tick that may carry a
// zero-crossing capture of a free-running 16-bit timer. The block updates the period,
// qualifies it over runs of good and bad periods, and derives the line frequency in
// 0.1 Hz units and the one-sixth-period trigger interval, then returns one result per
// tick. Each item is handled in order before the next input transfer is taken: the capture
// is taken, the bit-serial divider runs (10000000 / period and period / 6 run side by side,
// one quotient bit per cycle), and state is updated and the output register loaded, which
// waits while a stalled result still holds the output register. The result register
// lets a finished result wait while the next tick is taken. Write configuration only
// while idle.
// depends on lfm_pkg and lfm_div_serial
`default_nettype none

module line_frequency_meter_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic                         i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_capture_valid,
    input  wire logic [lfm_pkg::PERIOD_W-1:0] i_capture_time,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [lfm_pkg::PERIOD_W-1:0]      o_period_ticks,
    output logic [lfm_pkg::FREQ_W-1:0]        o_frequency_tenths,
    output logic                              o_zero_ok,
    output logic [lfm_pkg::SIXTH_W-1:0]       o_line_sixth
);
    import lfm_pkg::*;

    t_state              r_state, n_state;
    logic                r_auto;
    logic                r_mode;
    logic [PERIOD_W-1:0] r_last;
    logic [PERIOD_W-1:0] r_period;
    logic [RUN_W-1:0]    r_good, n_good;
    logic [RUN_W-1:0]    r_bad, n_bad;
    logic                r_zok, n_zok;
    logic [FREQ_W-1:0]   r_freq, n_freq;
    logic [SIXTH_W-1:0]  n_sixth;
    logic                r_out_valid;

    logic                in_xfer;
    logic                slot_free;
    logic                finish;
    logic                later;
    logic [PERIOD_W-1:0] new_period;
    logic [PERIOD_W-1:0] div_period;
    logic                is_good;
    t_div_sts            div_sts;

    lfm_div_serial u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer),
        .i_period (div_period),
        .o_sts    (div_sts)
    );

    assign div_period = i_capture_valid ? new_period : r_period;

    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign finish     = (r_state == ST_CALC) && div_sts.done && slot_free;

    // wrap case drops one tick, equal captures give 65535
    assign later      = (i_capture_time > r_last);
    assign new_period = i_capture_time - r_last - {{(PERIOD_W-1){1'b0}}, ~later};

    assign is_good = (r_period > GOOD_LO) && (r_period < GOOD_HI);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_CALC;
            ST_CALC: if (finish) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (is_good) begin
            n_bad  = '0;
            n_good = (r_good < RUN_MAX) ? r_good + 1'b1 : RUN_MAX;
        end else begin
            n_good = '0;
            n_bad  = (r_bad < RUN_MAX) ? r_bad + 1'b1 : RUN_MAX;
        end
        n_zok = r_zok;
        if (n_good > RUN_LIMIT) n_zok = 1'b1;
        if (n_bad > RUN_LIMIT) n_zok = 1'b0;
        n_freq = r_freq;
        if ((r_period > GOOD_LO) && (r_period < FREQ_HI)) n_freq = div_sts.freq_q;
        if ((div_sts.sixth > SIXTH_LO) && (div_sts.sixth < SIXTH_HI) && r_auto) begin
            n_sixth = div_sts.sixth[SIXTH_W-1:0];
        end else begin
            n_sixth = r_mode ? SIXTH_60HZ : SIXTH_50HZ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_auto      <= 1'b0;
            r_mode      <= 1'b0;
            r_last      <= '0;
            r_period    <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_zok       <= 1'b0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AUTO: r_auto <= i_cfg_data;
                    CFG_MODE: r_mode <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer && i_capture_valid) begin
                r_period <= new_period;
                r_last   <= i_capture_time;
            end
            if (finish) begin
                r_good  <= n_good;
                r_bad   <= n_bad;
                r_zok   <= n_zok;
                r_freq  <= n_freq;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_period_ticks     <= r_period;
            o_frequency_tenths <= n_freq;
            o_zero_ok          <= n_zok;
            o_line_sixth       <= n_sixth;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/lfm_div_serial.sv @@
// lfm_div_serial.sv
// bit-serial dividers: 10000000 / period and period / 6, one bit per cycle
// depends on lfm_pkg
`default_nettype none

module lfm_div_serial (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lfm_pkg::PERIOD_W-1:0]  i_period,
    output lfm_pkg::t_div_sts                  o_sts
);
    import lfm_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic [FREQ_W-1:0]   r_dbits;
    logic [FREQ_W-1:0]   r_quot;
    logic [PERIOD_W-1:0] r_pshift;
    logic [2:0]          r_rem6;
    logic [Q6_W-1:0]     r_q6;

    logic [PERIOD_W+1:0] trial;
    logic [3:0]          t6;
    logic                ge6;

    assign trial = {1'b0, r_rem, r_dbits[FREQ_W-1]} - {2'b00, r_div};
    assign t6    = {r_rem6, r_pshift[PERIOD_W-1]};
    assign ge6   = (t6 >= 4'd6);

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy && (r_step == LAST_STEP)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            if (i_start) begin
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div    <= i_period;
            r_rem    <= DIV_PRE;
            r_dbits  <= DIV_LOW;
            r_quot   <= '0;
            r_pshift <= i_period;
            r_rem6   <= '0;
            r_q6     <= '0;
        end else if (r_busy) begin
            // restoring step against the period
            if (r_step < DIV_STEPS) begin
                r_dbits <= {r_dbits[FREQ_W-2:0], 1'b0};
                r_quot  <= {r_quot[FREQ_W-2:0], ~trial[PERIOD_W+1]};
                if (!trial[PERIOD_W+1]) begin
                    r_rem <= trial[PERIOD_W-1:0];
                end else begin
                    r_rem <= {r_rem[PERIOD_W-2:0], r_dbits[FREQ_W-1]};
                end
            end
            // division by six, msb first
            r_pshift <= {r_pshift[PERIOD_W-2:0], 1'b0};
            r_rem6   <= ge6 ? 3'(t6 - 4'd6) : t6[2:0];
            r_q6     <= {r_q6[Q6_W-2:0], ge6};
        end
    end

    assign o_sts.done   = r_done;
    assign o_sts.freq_q = r_quot;
    assign o_sts.sixth  = r_q6;

endmodule

`default_nettype wire

@@ hw/rtl/lfm_checker.sv @@
// lfm_checker.sv
// port-level checks of the line frequency meter, bound to the top level
// depends on lfm_pkg and line_frequency_meter_unit_defines.svh
`default_nettype none
`include "line_frequency_meter_unit_defines.svh"

module lfm_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [lfm_pkg::PERIOD_W-1:0] o_period_ticks,
    input wire logic [lfm_pkg::FREQ_W-1:0]   o_frequency_tenths,
    input wire logic [lfm_pkg::SIXTH_W-1:0]  o_line_sixth
);
    import lfm_pkg::*;

    // a stalled result stays put
    `LFM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_period_ticks), "stalled result changed")

    // one tick at a time: a transfer closes the input side
    `LFM_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while busy")

    // sixth is a fixed default or a measured value in the trigger window
    `LFM_ASSERT_SAME(a_sixth_rng, i_clk, i_rst_n, o_out_valid, (o_line_sixth > SIXTH_LO[SIXTH_W-1:0]) && (o_line_sixth < SIXTH_HI[SIXTH_W-1:0]), "line sixth out of window")

    // frequency is either never set or inside the valid band
    `LFM_ASSERT_SAME(a_freq_rng, i_clk, i_rst_n, o_out_valid, (o_frequency_tenths == '0) || ((o_frequency_tenths >= FREQ_MIN) && (o_frequency_tenths <= FREQ_MAX)), "frequency out of band")

endmodule

bind line_frequency_meter_unit lfm_checker u_lfm_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
// testbench.sv
// self-checking testbench of line_frequency_meter_unit: queued ticks, clocked driver and
// monitor, in-line prediction of period, frequency, qualification flag and line sixth
// depends on lfm_pkg and the line_frequency_meter_unit rtl
`timescale 1ns / 1ps

module testbench;

    localparam int PERIOD_MAX     = 65535;
    localparam int BAND_GOOD_LO   = 16000;
    localparam int BAND_GOOD_HI   = 22000;
    localparam int BAND_FREQ_HI   = 25000;
    localparam int FREQ_SCALE     = 10000000;
    localparam int SIXTH_BAND_LO  = 2700;
    localparam int SIXTH_BAND_HI  = 3400;
    localparam int SIXTH_FIX_50   = 3333;
    localparam int SIXTH_FIX_60   = 2777;
    localparam int RUN_SAT        = 255;
    localparam int RUN_QUALIFY    = 3;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_TICKS    = 190;

    typedef struct packed {
        logic                         cap;
        logic [lfm_pkg::PERIOD_W-1:0] t;
    } t_tick;

    typedef struct packed {
        logic [lfm_pkg::PERIOD_W-1:0] period;
        logic [lfm_pkg::FREQ_W-1:0]   freq;
        logic                         zok;
        logic [lfm_pkg::SIXTH_W-1:0]  sixth;
    } t_meas;

    typedef enum int {
        RUN_GOOD,
        RUN_AUTO,
        RUN_FREQ,
        RUN_BAD,
        RUN_NOISE,
        RUN_EDGE
    } t_run_kind;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_index = 1'b0;
    logic                         i_cfg_data = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_capture_valid = 1'b0;
    logic [lfm_pkg::PERIOD_W-1:0] i_capture_time = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [lfm_pkg::PERIOD_W-1:0] o_period_ticks;
    logic [lfm_pkg::FREQ_W-1:0]   o_frequency_tenths;
    logic                         o_zero_ok;
    logic [lfm_pkg::SIXTH_W-1:0]  o_line_sixth;

    line_frequency_meter_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_capture_valid    (i_capture_valid),
        .i_capture_time     (i_capture_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_period_ticks     (o_period_ticks),
        .o_frequency_tenths (o_frequency_tenths),
        .o_zero_ok          (o_zero_ok),
        .o_line_sixth       (o_line_sixth)
    );

    // predicted meter state and register copy
    logic                         cfg_auto = 1'b0;
    logic                         cfg_sixty = 1'b0;
    logic [lfm_pkg::PERIOD_W-1:0] st_last_cap = '0;
    logic [lfm_pkg::PERIOD_W-1:0] st_period = '0;
    logic [lfm_pkg::RUN_W-1:0]    st_good_run = '0;
    logic [lfm_pkg::RUN_W-1:0]    st_bad_run = '0;
    logic                         st_zero_ok = 1'b0;
    logic [lfm_pkg::FREQ_W-1:0]   st_freq = '0;
    logic [lfm_pkg::SIXTH_W-1:0]  st_sixth = lfm_pkg::SIXTH_W'(SIXTH_FIX_50);

    t_tick tick_queue[$];
    t_meas expected_meas[$];
    t_tick cur_tick = '0;

    int gen_last = 0;
    int ticks_queued = 0;
    int ticks_sent = 0;
    int caps_sent = 0;
    int checked_results = 0;
    int zero_ok_results = 0;
    int measured_sixths = 0;
    int mismatches = 0;
    int errors = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int stall_style = 0;
    int style_left = 0;
    int idle_cycles = 0;

    function automatic t_meas predict_measurement(t_tick tk);
        t_meas m;
        int p;
        int sixth;
        if (tk.cap) begin
            if (tk.t > st_last_cap)
                st_period = tk.t - st_last_cap;
            else
                st_period = 16'hFFFF - st_last_cap + tk.t;
            st_last_cap = tk.t;
        end
        p = int'(st_period);
        if (p > BAND_GOOD_LO && p < BAND_GOOD_HI) begin
            st_bad_run = '0;
            if (st_good_run != RUN_SAT)
                st_good_run = st_good_run + 1'b1;
        end else begin
            st_good_run = '0;
            if (st_bad_run != RUN_SAT)
                st_bad_run = st_bad_run + 1'b1;
        end
        if (st_good_run > RUN_QUALIFY)
            st_zero_ok = 1'b1;
        if (st_bad_run > RUN_QUALIFY)
            st_zero_ok = 1'b0;
        if (p > BAND_GOOD_LO && p < BAND_FREQ_HI)
            st_freq = lfm_pkg::FREQ_W'(FREQ_SCALE / p);
        sixth = p / 6;
        if (sixth > SIXTH_BAND_LO && sixth < SIXTH_BAND_HI && cfg_auto) begin
            st_sixth = lfm_pkg::SIXTH_W'(sixth);
            measured_sixths++;
        end else begin
            st_sixth = lfm_pkg::SIXTH_W'(cfg_sixty ? SIXTH_FIX_60 : SIXTH_FIX_50);
        end
        m.period = st_period;
        m.freq = st_freq;
        m.zok = st_zero_ok;
        m.sixth = st_sixth;
        return m;
    endfunction

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_tick nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_meas.push_back(predict_measurement(cur_tick));
                ticks_sent <= ticks_sent + 1;
                if (cur_tick.cap)
                    caps_sent <= caps_sent + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    nxt = tick_queue.pop_front();
                    cur_tick <= nxt;
                    i_capture_valid <= nxt.cap;
                    i_capture_time <= nxt.t;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: changing stall styles plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && ticks_sent >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (style_left == 0) begin
                stall_style <= $urandom_range(0, 3);
                style_left <= $urandom_range(40, 200);
            end else begin
                style_left <= style_left - 1;
            end
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_meas want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_meas.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result with nothing expected: ",
                              "period %0d freq %0d zero_ok %0d sixth %0d"},
                             o_period_ticks, o_frequency_tenths, o_zero_ok, o_line_sixth);
            end else begin
                want = expected_meas.pop_front();
                checked_results++;
                if (want.zok)
                    zero_ok_results++;
                if (o_period_ticks !== want.period || o_frequency_tenths !== want.freq ||
                    o_zero_ok !== want.zok || o_line_sixth !== want.sixth) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on result %0d: ",
                                  "expected %0d %0d %0d %0d, got %0d %0d %0d %0d"},
                                 checked_results, want.period, want.freq, want.zok,
                                 want.sixth, o_period_ticks, o_frequency_tenths,
                                 o_zero_ok, o_line_sixth);
                end
            end
        end
    end

    // watchdog on transfers of either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", expected_meas.size());
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic queue_tick(input logic cap, input logic [lfm_pkg::PERIOD_W-1:0] t);
        t_tick tk;
        tk.cap = cap;
        tk.t = t;
        if (cap)
            gen_last = int'(t);
        tick_queue.push_back(tk);
        ticks_queued++;
    endtask

    // capture placed so the measured period comes out as p; a p of 0 gives an equal capture, measured as 65535
    task automatic queue_capture(input int p);
        int nt;
        nt = gen_last + p;
        if (nt > PERIOD_MAX)
            nt = nt + 1 - (PERIOD_MAX + 1);
        queue_tick(1'b1, nt[lfm_pkg::PERIOD_W-1:0]);
    endtask

    function automatic int boundary_period(input int sel);
        case (sel)
            0: return 0;
            1: return 16000;
            2: return 16001;
            3: return 16205;
            4: return 16206;
            5: return 16667;
            6: return 20399;
            7: return 20400;
            8: return 21999;
            9: return 22000;
            10: return 24999;
            11: return 25000;
            default: return PERIOD_MAX;
        endcase
    endfunction

    task automatic queue_run(input t_run_kind k, input int len);
        int base;
        int i;
        case (k)
            RUN_GOOD: base = $urandom_range(16041, 21959);
            RUN_AUTO: base = $urandom_range(16246, 20359);
            RUN_FREQ: base = $urandom_range(22040, 24959);
            default:  base = 0;
        endcase
        for (i = 0; i < len; i++) begin
            case (k)
                RUN_GOOD, RUN_AUTO, RUN_FREQ: begin
                    if ($urandom_range(0, 4) == 0)
                        queue_tick(1'b0, lfm_pkg::PERIOD_W'($urandom));
                    else
                        queue_capture(base + $urandom_range(0, 80) - 40);
                end
                RUN_BAD: begin
                    case ($urandom_range(0, 2))
                        0: queue_tick(1'b0, lfm_pkg::PERIOD_W'($urandom));
                        1: queue_capture($urandom_range(1, BAND_GOOD_LO));
                        default: queue_capture($urandom_range(BAND_FREQ_HI, PERIOD_MAX));
                    endcase
                end
                RUN_NOISE: queue_tick(1'($urandom_range(0, 1)), lfm_pkg::PERIOD_W'($urandom));
                default: queue_capture(boundary_period($urandom_range(0, 12)));
            endcase
        end
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == lfm_pkg::CFG_AUTO)
            cfg_auto = val;
        else
            cfg_sixty = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || i_in_valid || expected_meas.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic auto_on, input logic sixty, input int forced);
        int start;
        int r;
        t_run_kind k;
        wait_idle();
        write_reg(lfm_pkg::CFG_AUTO, auto_on);
        write_reg(lfm_pkg::CFG_MODE, sixty);
        @(negedge i_clk);
        start = ticks_queued;
        if (forced == 1)
            queue_run(RUN_GOOD, 268);
        else if (forced == 2)
            queue_run(RUN_BAD, 268);
        while (ticks_queued - start < PHASE_TICKS) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                k = RUN_GOOD;
            else if (r < 55)
                k = RUN_AUTO;
            else if (r < 67)
                k = RUN_FREQ;
            else if (r < 80)
                k = RUN_BAD;
            else if (r < 92)
                k = RUN_NOISE;
            else
                k = RUN_EDGE;
            queue_run(k, $urandom_range(1, 24));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(lfm_pkg::CFG_AUTO, 1'b1);
        write_reg(lfm_pkg::CFG_MODE, 1'b0);
        @(negedge i_clk);

        // tick before any capture, then equal and extreme captures
        queue_tick(1'b0, 16'hFFFF);
        queue_tick(1'b1, 16'h0000);
        queue_tick(1'b1, 16'hFFFF);
        repeat (4) queue_capture(20000);
        queue_tick(1'b0, 16'h0000);
        queue_capture(16000);
        queue_capture(16001);
        queue_capture(16205);
        queue_capture(16206);
        queue_capture(20399);
        queue_capture(20400);
        queue_capture(21999);
        queue_capture(22000);
        queue_capture(24999);
        queue_capture(25000);
        queue_capture(0);
        repeat (4) queue_tick(1'b0, lfm_pkg::PERIOD_W'($urandom));

        run_phase(1'b1, 1'b1, 1);
        run_phase(1'b0, 1'b1, 0);
        run_phase(1'b1, 1'b0, 2);
        run_phase(1'b0, 1'b0, 0);
        run_phase(1'b1, 1'b1, 0);

        while (tick_queue.size() != 0 || i_in_valid || expected_meas.size() != 0)
            @(negedge i_clk);
        repeat (40) @(posedge i_clk);

        errors = mismatches + expected_meas.size();
        $display("ran %0d ticks, %0d carrying a capture, over five register settings",
                 ticks_sent, caps_sent);
        $display("checked %0d results: %0d qualified, %0d with a measured sixth",
                 checked_results, zero_ok_results, measured_sixths);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
